// ----- hdl/aes_cbc_pkg.sv -----
// ----------------------------------------------------------------------------
// AES-128 CBC package
// Shared types, register map and AES helper functions.
// ----------------------------------------------------------------------------
package aes_cbc_pkg;

    localparam int BLOCK_W   = 128;
    localparam int HALF_W    = 64;
    localparam int NUM_ROUNDS = 10;
    localparam int ROUND_W   = 4;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ADDR_W-1:0] REG_KEY_HI = 5'd0;
    localparam logic [ADDR_W-1:0] REG_KEY_LO = 5'd8;
    localparam logic [ADDR_W-1:0] REG_IV_HI  = 5'd16;
    localparam logic [ADDR_W-1:0] REG_IV_LO  = 5'd24;

    localparam logic [HALF_W-1:0] IV_RESET_HI = 64'h0001020304050607;
    localparam logic [HALF_W-1:0] IV_RESET_LO = 64'h08090a0b0c0d0e0f;

    // Queue entry between front and back.
    typedef struct packed {
        logic [BLOCK_W-1:0] plain;
        logic               restart;
    } job_t;

    typedef logic [7:0] byte_t;

    function automatic byte_t sbox(input byte_t x);
        byte_t t [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic byte_t xtime(input byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits at bits [127-8i -: 8].
    function automatic byte_t blk_byte(input logic [BLOCK_W-1:0] b, input int i);
        return b[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[BLOCK_W-1-8*(4*c+r) -: 8] = sbox(blk_byte(s, (4*(c+r)+r) % 16));
        return t;
    endfunction

    function automatic logic [BLOCK_W-1:0] mix_cols(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] t;
        byte_t a0, a1, a2, a3, al;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = blk_byte(s, 4*c);
            a1 = blk_byte(s, 4*c+1);
            a2 = blk_byte(s, 4*c+2);
            a3 = blk_byte(s, 4*c+3);
            al = a0 ^ a1 ^ a2 ^ a3;
            t[BLOCK_W-1-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                       a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
        end
        return t;
    endfunction

    function automatic byte_t rcon(input logic [ROUND_W-1:0] r);
        byte_t v;
        unique case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Next round key from the current one; r is the round being produced.
    function automatic logic [BLOCK_W-1:0] next_key(input logic [BLOCK_W-1:0] k,
                                                    input logic [ROUND_W-1:0] r);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ----- hdl/aes128_cbc_encrypt_core.sv -----
// From input transfer to output valid on an idle core: the queue entry, then
// the ten rounds of the round engine, the last of which loads the output register.
// The single shared round unit takes the next queued block as the current one finishes.
// Reset (rst_n, asynchronous, active low): queue empty, key zero, IV and
// chaining value at 00..0f.
// ----------------------------------------------------------------------------
// AES-128 CBC encryption core
// APB register file, input queue (front) and iterative round engine (back).
// ----------------------------------------------------------------------------
module aes128_cbc_encrypt_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [aes_cbc_pkg::ADDR_W-1:0]   paddr,
    input  logic [aes_cbc_pkg::DATA_W-1:0]   pwdata,
    output logic [aes_cbc_pkg::DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [aes_cbc_pkg::HALF_W-1:0]   plain_high,
    input  logic [aes_cbc_pkg::HALF_W-1:0]   plain_low,
    input  logic                             restart_chain,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [aes_cbc_pkg::HALF_W-1:0]   cipher_high,
    output logic [aes_cbc_pkg::HALF_W-1:0]   cipher_low
);
    import aes_cbc_pkg::*;

    logic [HALF_W-1:0]  key_hi_reg, key_lo_reg, iv_hi_reg, iv_lo_reg;
    logic               wr_en;
    job_t               in_job, job;
    logic               job_valid, job_take, busy;
    logic [BLOCK_W-1:0] out_data;

    // Register file: 64-bit registers at 8-byte strides; pready tied high.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
            iv_hi_reg  <= IV_RESET_HI;
            iv_lo_reg  <= IV_RESET_LO;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                REG_KEY_HI: key_hi_reg <= pwdata;
                REG_KEY_LO: key_lo_reg <= pwdata;
                REG_IV_HI:  iv_hi_reg  <= pwdata;
                REG_IV_LO:  iv_lo_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_KEY_HI: prdata = key_hi_reg;
            REG_KEY_LO: prdata = key_lo_reg;
            REG_IV_HI:  prdata = iv_hi_reg;
            REG_IV_LO:  prdata = iv_lo_reg;
            default:    prdata = '0;
        endcase
    end

    assign in_job = '{plain: {plain_high, plain_low}, restart: restart_chain};

    // Front: classifies nothing beyond queueing; the restart flag rides along.
    aes_cbc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_job    (in_job),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job)
    );

    // Back: ten rounds, chaining value held here across transfers.
    aes_cbc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job),
        .key       ({key_hi_reg, key_lo_reg}),
        .iv        ({iv_hi_reg, iv_lo_reg}),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .busy      (busy)
    );

    assign cipher_high = out_data[BLOCK_W-1:HALF_W];
    assign cipher_low  = out_data[HALF_W-1:0];

`ifndef SYNTHESIS
    // A block is only taken from a non-empty queue; it starts when the engine is free or finishing.
    a_take_ok: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> job_valid)
        else $error("job taken from empty queue");

    // Held output does not change while stalled.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("output changed under stall");

    // The queue only fills up while the engine is occupied.
    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> busy)
        else $error("queue full with idle engine");
`endif

endmodule

// ----- hdl/aes_cbc_front.sv -----
// ----------------------------------------------------------------------------
// AES-128 CBC front end
// Takes input transfers into a two-entry queue for the round engine.
// ----------------------------------------------------------------------------
module aes_cbc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  aes_cbc_pkg::job_t   in_job,
    output logic                job_valid,
    input  logic                job_take,
    output aes_cbc_pkg::job_t   job
);
    import aes_cbc_pkg::*;

    job_t       mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_stall  = (count_reg == 2'(QUEUE_DEPTH));
    assign push      = in_valid && !in_stall;
    assign job_valid = (count_reg != 2'd0);
    assign pop       = job_valid && job_take;
    assign job       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= in_job;
    end

endmodule

// ----- hdl/aes_cbc_back.sv -----
// ----------------------------------------------------------------------------
// AES-128 CBC round engine; the last round waits on a stalled full output.
// One AES round per cycle with on-the-fly key schedule, chaining and output.
// ----------------------------------------------------------------------------
module aes_cbc_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_take,
    input  aes_cbc_pkg::job_t             job,
    input  logic [aes_cbc_pkg::BLOCK_W-1:0] key,
    input  logic [aes_cbc_pkg::BLOCK_W-1:0] iv,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [aes_cbc_pkg::BLOCK_W-1:0] out_data,
    output logic                          busy
);
    import aes_cbc_pkg::*;

    logic                  run_reg;
    logic [ROUND_W-1:0]    round_reg;
    logic [BLOCK_W-1:0]    state_reg, rkey_reg, chain_reg, out_reg;
    logic                  out_valid_reg;
    logic [BLOCK_W-1:0]    ss, rk_new, round_out, chain_sel;
    logic                  last, finish;

    assign busy      = run_reg;
    assign last      = (round_reg == 4'(NUM_ROUNDS));
    // A finished block may leave when the output register is free or draining.
    assign finish    = run_reg && last && (!out_valid_reg || !out_stall);
    assign job_take  = job_valid && (!run_reg || finish);
    assign chain_sel = job.restart ? iv : chain_reg;

    always_comb
    begin
        ss        = sub_shift(state_reg);
        rk_new    = next_key(rkey_reg, round_reg);
        round_out = (last ? ss : mix_cols(ss)) ^ rk_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
            chain_reg     <= {IV_RESET_HI, IV_RESET_LO};
        end
        else
        begin
            if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                chain_reg     <= round_out;
            end
            if (job_take)
            begin
                run_reg   <= 1'b1;
                round_reg <= 4'd1;
            end
            else if (finish)
                run_reg <= 1'b0;
            else if (run_reg && !last)
                round_reg <= round_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            // Back-to-back chaining: use the block just finishing.
            state_reg <= job.plain ^ (finish && !job.restart ? round_out : chain_sel) ^ key;
            rkey_reg  <= key;
        end
        else if (run_reg && !last)
        begin
            state_reg <= round_out;
            rkey_reg  <= rk_new;
        end
        if (finish) out_reg <= round_out;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 CBC encryption core testbench
// Drives plaintext blocks with random idling on both sides, writes the
// key and IV registers between phases, and checks every ciphertext block
// against a cycle-free AES-128 CBC predictor kept in step with each transfer.
// ----------------------------------------------------------------------------
module tb;

    import aes_cbc_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_stall;
    logic [HALF_W-1:0]   plain_high;
    logic [HALF_W-1:0]   plain_low;
    logic                restart_chain;
    logic                out_valid;
    logic                out_stall;
    logic [HALF_W-1:0]   cipher_high;
    logic [HALF_W-1:0]   cipher_low;

    aes128_cbc_encrypt_core dut
    (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .plain_high(plain_high), .plain_low(plain_low), .restart_chain(restart_chain),
        .out_valid(out_valid), .out_stall(out_stall),
        .cipher_high(cipher_high), .cipher_low(cipher_low)
    );

    // Predictor state: configuration copy and the chaining value.
    logic [127:0] key_reg;
    logic [127:0] iv_reg;
    logic [127:0] chain_reg;

    // Expected ciphertext blocks, oldest first.
    logic [127:0] cipher_fifo [$];

    int  fail_count;
    bit  idle_on;       // random idling enabled
    bit  hold_rx;       // receiver forced hold-off
    int  hold_cycles;

    localparam int IDX_KEY_HI = 0;
    localparam int IDX_KEY_LO = 1;
    localparam int IDX_IV_HI  = 2;
    localparam int IDX_IV_LO  = 3;

    // ------------------------------------------------------------------------
    // Predictor tables and helpers, written independently of the package.
    // ------------------------------------------------------------------------
    logic [7:0] sb [256];

    initial
    begin
        sb = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    end

    function automatic logic [7:0] gmul2(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // State kept as 16 bytes, byte 0 = most significant of the block.
    function automatic logic [127:0] aes_encrypt(input logic [127:0] blk,
                                                 input logic [127:0] key);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] rk [176];
        logic [7:0] w0, w1, w2, w3, tmp, a0, a1, a2, a3, al, rc;
        logic [127:0] res;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = key[127-8*i -: 8];
            s[i]  = blk[127-8*i -: 8] ^ rk[i];
        end
        rc = 8'h01;
        for (int i = 16; i < 176; i += 4)
        begin
            w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
            if (i % 16 == 0)
            begin
                tmp = w0;
                w0 = sb[w1] ^ rc;
                w1 = sb[w2];
                w2 = sb[w3];
                w3 = sb[tmp];
                rc = gmul2(rc);
            end
            rk[i]   = rk[i-16] ^ w0;
            rk[i+1] = rk[i-15] ^ w1;
            rk[i+2] = rk[i-14] ^ w2;
            rk[i+3] = rk[i-13] ^ w3;
        end
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    t[4*c+w] = sb[s[(4*(c+w)+w) % 16]];
            if (r != 10)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
                    t[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
                    t[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
                    t[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
                end
            for (int i = 0; i < 16; i++)
                s[i] = t[i] ^ rk[16*r+i];
        end
        for (int i = 0; i < 16; i++)
            res[127-8*i -: 8] = s[i];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Register write: setup then access phase, on falling edges.
    // ------------------------------------------------------------------------
    task automatic write_reg(input int idx, input logic [63:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(8 * idx);
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            IDX_KEY_HI: key_reg[127:64] = val;
            IDX_KEY_LO: key_reg[63:0]   = val;
            IDX_IV_HI:  iv_reg[127:64]  = val;
            IDX_IV_LO:  iv_reg[63:0]    = val;
            default: ;
        endcase
    endtask

    task automatic write_key(input logic [127:0] k);
        write_reg(IDX_KEY_HI, k[127:64]);
        write_reg(IDX_KEY_LO, k[63:0]);
    endtask

    task automatic write_iv(input logic [127:0] v);
        write_reg(IDX_IV_HI, v[127:64]);
        write_reg(IDX_IV_LO, v[63:0]);
    endtask

    // ------------------------------------------------------------------------
    // Send one block; the prediction is made at the accepting edge.
    // valid stays high after the transfer so blocks can follow back to back;
    // an idle gap or drain() drops it.
    // ------------------------------------------------------------------------
    task automatic send_block(input logic [127:0] pt, input logic rs);
        logic [127:0] ch;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid      <= 1'b1;
        plain_high    <= pt[127:64];
        plain_low     <= pt[63:0];
        restart_chain <= rs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ch = rs ? iv_reg : chain_reg;
        chain_reg = aes_encrypt(pt ^ ch, key_reg);
        cipher_fifo.push_back(chain_reg);
    endtask

    // Wait for every expected transfer, then allow the core to settle.
    task automatic drain;
        int guard;
        guard = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (cipher_fifo.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (30) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, forced hold-off when requested.
    // ------------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rx)
            begin
                out_stall <= 1'b1;
                hold_cycles = 0;
                while (hold_cycles < 300)
                begin
                    @(negedge clk);
                    hold_cycles++;
                end
                hold_rx = 1'b0;
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Checker: compare each output transfer with the oldest expectation.
    always @(posedge clk)
    begin
        logic [127:0] exp_blk;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cipher_fifo.size() == 0)
            begin
                $display("%0t: unexpected output %h %h", $time, cipher_high, cipher_low);
                fail_count++;
            end
            else
            begin
                exp_blk = cipher_fifo.pop_front();
                if (cipher_high !== exp_blk[127:64])
                begin
                    $display("%0t: cipher_high expected %h actual %h",
                             $time, exp_blk[127:64], cipher_high);
                    fail_count++;
                end
                if (cipher_low !== exp_blk[63:0])
                begin
                    $display("%0t: cipher_low expected %h actual %h",
                             $time, exp_blk[63:0], cipher_low);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [127:0] rand_block();
        return {$urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // No restart on the first block after reset: chains from the reset IV.
    task automatic test_reset_chain;
        send_block(128'h0, 1'b0);
        send_block({128{1'b1}}, 1'b0);
        drain();
    endtask

    // FIPS-197 known answer and field extremes; IV write alone does not move
    // the chaining value.
    task automatic test_directed;
        write_key(128'h000102030405060708090a0b0c0d0e0f);
        write_iv(128'h0);
        send_block(128'h00112233445566778899aabbccddeeff, 1'b1);
        send_block(128'h0, 1'b0);
        send_block({128{1'b1}}, 1'b0);
        drain();
        write_iv({128{1'b1}});
        send_block(128'h8000_0000_0000_0000_0000_0000_0000_0001, 1'b0);
        send_block(128'h0, 1'b1);
        send_block({64'h0, {64{1'b1}}}, 1'b0);
        drain();
        send_block(rand_block(), 1'b0);
        drain();
    endtask

    // New key mid-message keeps the chaining value.
    task automatic test_key_change;
        write_key({128{1'b1}});
        send_block(rand_block(), 1'b0);
        send_block(rand_block(), 1'b0);
        drain();
        write_key(128'h0);
        send_block(rand_block(), 1'b0);
        drain();
    endtask

    // Sender keeps offering while the receiver holds off.
    task automatic test_backpressure;
        hold_rx = 1'b1;
        for (int i = 0; i < 12; i++)
            send_block(rand_block(), i == 0);
        drain();
    endtask

    // Random messages of random length; several configurations.
    task automatic test_random(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(1, 12);
            for (int j = 0; j < len && sent < n_items; j++)
            begin
                send_block(rand_block(), j == 0 ? 1'b1 : ($urandom_range(0, 15) == 0));
                sent++;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                drain();
                if ($urandom_range(0, 1))
                    write_key(rand_block());
                else
                    write_iv(rand_block());
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        plain_high    = '0;
        plain_low     = '0;
        restart_chain = 1'b0;
        fail_count    = 0;
        idle_on       = 1'b1;
        hold_rx       = 1'b0;
        key_reg       = 128'h0;
        iv_reg        = {IV_RESET_HI, IV_RESET_LO};
        chain_reg     = {IV_RESET_HI, IV_RESET_LO};
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_reset_chain();
        test_directed();
        test_key_change();
        test_backpressure();
        write_key(rand_block());
        write_iv(rand_block());
        test_random(1000);
        // Final stretch with no idling on either side.
        idle_on = 1'b0;
        test_random(150);

        if (fail_count == 0 && cipher_fifo.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
